### src/aesccm_pkg.sv
// Shared types, constants and AES helper functions for the AES-128 CCM cipher.
// No dependencies; imported by aesccm_core and aes_ccm_authenticated_cipher.
`default_nettype none
package aesccm_pkg;

  localparam int BLK_W   = 128;
  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 144;

  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_AAD     = 2'd1;
  localparam logic [1:0] MODE_PAYLOAD = 2'd2;
  localparam logic [1:0] MODE_FINISH  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_OVERRUN = 2'd1;
  localparam logic [1:0] ST_EARLY   = 2'd2;
  localparam logic [1:0] ST_SEQ     = 2'd3;

  localparam logic [1:0] REG_KEY_HIGH = 2'd0;
  localparam logic [1:0] REG_KEY_LOW  = 2'd1;
  localparam logic [1:0] REG_TAG_LEN  = 2'd2;
  localparam logic [1:0] REG_CTR_SIZE = 2'd3;

  localparam logic [15:0] AAD_LIMIT = 16'hFF00;
  localparam logic [7:0]  AAD_FLAG  = 8'h40;
  localparam logic [3:0]  AES_ROUNDS = 4'd10;

  typedef enum logic [1:0] {
    PH_IDLE, PH_AAD, PH_PAYLOAD, PH_DONE
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START_W, S_AAD_W, S_KS_W, S_PAY, S_PAYMAC_W,
    S_FINMAC_W, S_FINKS, S_FINKS_W, S_TAG
  } state_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a block sits at bits [127-8i -: 8].
  function automatic logic [7:0] get_byte(input logic [127:0] b, input int i);
    get_byte = b[8*(15-i) +: 8];
  endfunction

  function automatic logic [127:0] key_expand(input logic [127:0] rk, input logic [7:0] rc);
    logic [31:0] tmp, w0, w1, w2, w3;
    tmp = {SBOX[get_byte(rk, 13)] ^ rc, SBOX[get_byte(rk, 14)],
           SBOX[get_byte(rk, 15)], SBOX[get_byte(rk, 12)]};
    w0 = rk[127:96] ^ tmp;
    w1 = rk[95:64] ^ w0;
    w2 = rk[63:32] ^ w1;
    w3 = rk[31:0] ^ w2;
    key_expand = {w0, w1, w2, w3};
  endfunction

  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                             input logic last);
    logic [127:0] t;
    logic [7:0] a0, a1, a2, a3, e;
    t = '0;
    for (int c = 0; c < 4; c++) begin
      for (int j = 0; j < 4; j++) begin
        t[8*(15-(j+4*c)) +: 8] = SBOX[get_byte(s, j + 4*((c + j) & 3))];
      end
    end
    if (!last) begin
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(t, 4*c);
        a1 = get_byte(t, 4*c+1);
        a2 = get_byte(t, 4*c+2);
        a3 = get_byte(t, 4*c+3);
        e  = a0 ^ a1 ^ a2 ^ a3;
        t[8*(15-4*c) +: 8]     = a0 ^ e ^ xt(a0 ^ a1);
        t[8*(15-4*c-1) +: 8]   = a1 ^ e ^ xt(a1 ^ a2);
        t[8*(15-4*c-2) +: 8]   = a2 ^ e ^ xt(a2 ^ a3);
        t[8*(15-4*c-3) +: 8]   = a3 ^ e ^ xt(a3 ^ a0);
      end
    end
    aes_round = t ^ rk;
  endfunction

  // Write value big-endian into the last l bytes of the block.
  function automatic logic [127:0] put_tail(input logic [127:0] blk, input logic [63:0] v,
                                            input logic [3:0] l);
    logic [127:0] r;
    r = blk;
    for (int d = 0; d < 8; d++) begin
      if (4'(d) < l) r[8*d +: 8] = v[8*d +: 8];
    end
    put_tail = r;
  endfunction

endpackage
`default_nettype wire

### src/aesccm_core.sv
// Iterative AES-128 encryption unit: one round per cycle, key expanded on the fly.
// Depends on aesccm_pkg.
`default_nettype none
module aesccm_core
  import aesccm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         go,
  input  wire logic [127:0] blk,
  input  wire logic [127:0] key,
  output logic              done,
  output logic [127:0]      result
);

  logic [127:0] st_r, st_nxt, rk_r, rk_nxt, nk;
  logic [7:0]   rc_r, rc_nxt;
  logic [3:0]   rnd_r, rnd_nxt;
  logic         busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    nk       = key_expand(rk_r, rc_r);
    st_nxt   = st_r;
    rk_nxt   = rk_r;
    rc_nxt   = rc_r;
    rnd_nxt  = rnd_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go) begin
      st_nxt   = blk ^ key;
      rk_nxt   = key;
      rc_nxt   = 8'h01;
      rnd_nxt  = 4'd1;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      st_nxt  = aes_round(st_r, nk, rnd_r == AES_ROUNDS);
      rk_nxt  = nk;
      rc_nxt  = xt(rc_r);
      rnd_nxt = rnd_r + 4'd1;
      if (rnd_r == AES_ROUNDS) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    st_r  <= st_nxt;
    rk_r  <= rk_nxt;
    rc_r  <= rc_nxt;
    rnd_r <= rnd_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done   = done_r;
  assign result = st_r;

endmodule
`default_nettype wire

### src/aes_ccm_authenticated_cipher.sv
// AES-128 CCM authenticated cipher: sequencer, message state and stream ports.
// Depends on aesccm_pkg and aesccm_core.
//
//  channel | handshake             | payload
//  --------+-----------------------+-------------------------------------------
//  in      | in_tvalid / in_tready | in_tdata (fields), in_tuser (mode)
//  out     | out_tvalid/out_tready | out_tdata: byte, tag, status
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each AES pass on the shared round unit is a load followed by ten rounds.
// Start, an AAD byte that closes a block and a payload byte that opens or
// closes a block each run one AES pass; finish runs one or two, and a
// rejected beat or a repeated finish runs none.
// Reset is synchronous, active low; it clears the sequencer, phase and registers.
// in_tready is low while a beat is in work and while a result waits on
// out_tready; a result taken in the same cycle frees the input.
`default_nettype none
module aes_ccm_authenticated_cipher
  import aesccm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [0] encrypt_flag, [40:1] nonce_high, [104:41] nonce_low,
  // [120:105] aad_length, [152:121] message_length, [160:153] data_byte
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // [1:0] mode
  input  wire logic [1:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [7:0] out_byte, [71:8] tag_high, [135:72] tag_low, [137:136] status
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [63:0]            cfg_data
);

  // Input field split.
  logic         f_enc;
  logic [39:0]  f_nh;
  logic [63:0]  f_nl;
  logic [15:0]  f_aadl;
  logic [31:0]  f_msg;
  logic [7:0]   f_db;
  assign f_enc  = in_tdata[0];
  assign f_nh   = in_tdata[40:1];
  assign f_nl   = in_tdata[104:41];
  assign f_aadl = in_tdata[120:105];
  assign f_msg  = in_tdata[152:121];
  assign f_db   = in_tdata[160:153];

  // Configuration registers.
  logic [63:0] key_high_r, key_low_r;
  logic [4:0]  tag_len_r;
  logic [3:0]  ctr_size_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      tag_len_r  <= 5'd8;
      ctr_size_r <= 4'd2;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        REG_TAG_LEN:  tag_len_r  <= cfg_data[4:0];
        REG_CTR_SIZE: ctr_size_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Effective tag length (even, 4..16) and counter size (2..8).
  logic [4:0] eff_m;
  logic [3:0] eff_l;
  always_comb begin
    eff_m = tag_len_r;
    if (eff_m < 5'd4)  eff_m = 5'd4;
    if (eff_m > 5'd16) eff_m = 5'd16;
    eff_m[0] = 1'b0;
    eff_l = ctr_size_r;
    if (eff_l < 4'd2) eff_l = 4'd2;
    if (eff_l > 4'd8) eff_l = 4'd8;
  end

  // Message state.
  logic [127:0] mac_r, mac_nxt, cb_r, cb_nxt, ks_r, ks_nxt;
  logic [31:0]  pos_r, pos_nxt, total_r, total_nxt;
  logic [15:0]  rem_r, rem_nxt;
  logic [3:0]   fill_r, fill_nxt;
  logic         dir_r, dir_nxt;
  logic [7:0]   db_r, db_nxt;
  phase_t       phase_r, phase_nxt;
  state_t       state_r, state_nxt;

  // Result register.
  logic         ovalid_r, ovalid_nxt;
  logic [7:0]   obyte_r, obyte_nxt;
  logic [63:0]  otagh_r, otagh_nxt, otagl_r, otagl_nxt;
  logic [1:0]   ostat_r, ostat_nxt;

  // Shared AES unit.
  logic         aes_go, aes_done;
  logic [127:0] aes_blk, aes_out;

  aesccm_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (aes_go),
    .blk    (aes_blk),
    .key    ({key_high_r, key_low_r}),
    .done   (aes_done),
    .result (aes_out)
  );

  logic         accept;
  logic [127:0] b0, base, mac_upd, tagx;
  logic [3:0]   k, fill_inc;
  logic [15:0]  rem_dec;
  logic [31:0]  pos_inc;
  logic [7:0]   ob, flags;
  logic [2:0]   mfield;
  logic         bad;

  assign in_tready = (state_r == S_IDLE) && (!ovalid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    mac_nxt   = mac_r;
    cb_nxt    = cb_r;
    ks_nxt    = ks_r;
    pos_nxt   = pos_r;
    total_nxt = total_r;
    rem_nxt   = rem_r;
    fill_nxt  = fill_r;
    dir_nxt   = dir_r;
    db_nxt    = db_r;
    phase_nxt = phase_r;
    state_nxt = state_r;
    obyte_nxt = obyte_r;
    otagh_nxt = otagh_r;
    otagl_nxt = otagl_r;
    ostat_nxt = ostat_r;
    ovalid_nxt = ovalid_r && !out_tready;
    aes_go    = 1'b0;
    aes_blk   = mac_r;

    // B0 and the nonce base of the counter block.
    mfield = 3'(eff_m[4:1] - 4'd1);
    flags  = ((f_aadl != 16'd0) ? AAD_FLAG : 8'h00) | {2'b00, mfield, 3'b000}
             | {5'b0, 3'(eff_l - 4'd1)};
    base   = {8'h00, f_nh, f_nl, 16'h0000};
    b0     = put_tail({flags, base[119:0]}, {32'h0, f_msg}, eff_l);
    bad    = (f_aadl >= AAD_LIMIT)
             || ((eff_l == 4'd2) && (f_msg[31:16] != 16'd0))
             || ((eff_l == 4'd3) && (f_msg[31:24] != 8'd0));

    fill_inc = fill_r + 4'd1;
    rem_dec  = rem_r - 16'd1;
    k        = pos_r[3:0];
    pos_inc  = pos_r + 32'd1;
    mac_upd  = mac_r;
    ob       = db_r ^ ks_r[8*(15-k) +: 8];

    tagx = mac_r ^ ks_r;
    for (int b = 0; b < 16; b++) begin
      if (5'(b) >= eff_m) tagx[8*(15-b) +: 8] = 8'h00;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          obyte_nxt = 8'h00;
          otagh_nxt = '0;
          otagl_nxt = '0;
          ostat_nxt = ST_OK;
          case (in_tuser)
            MODE_START: begin
              if (bad) begin
                phase_nxt  = PH_IDLE;
                ostat_nxt  = ST_SEQ;
                ovalid_nxt = 1'b1;
              end else begin
                mac_nxt   = b0;
                cb_nxt    = put_tail({8'(eff_l - 4'd1), base[119:0]}, 64'h0, eff_l);
                ks_nxt    = '0;
                dir_nxt   = f_enc;
                pos_nxt   = '0;
                total_nxt = f_msg;
                rem_nxt   = f_aadl;
                fill_nxt  = (f_aadl != 16'd0) ? 4'd2 : 4'd0;
                phase_nxt = (f_aadl != 16'd0) ? PH_AAD : PH_PAYLOAD;
                aes_go    = 1'b1;
                aes_blk   = b0;
                state_nxt = S_START_W;
              end
            end
            MODE_AAD: begin
              if (phase_r != PH_AAD) begin
                ostat_nxt  = ST_SEQ;
                ovalid_nxt = 1'b1;
              end else begin
                mac_upd[8*(15-fill_r) +: 8] = mac_r[8*(15-fill_r) +: 8] ^ f_db;
                mac_nxt  = mac_upd;
                fill_nxt = fill_inc;
                rem_nxt  = rem_dec;
                if (rem_dec == 16'd0) begin
                  fill_nxt  = 4'd0;
                  phase_nxt = PH_PAYLOAD;
                end
                // Close the block when it fills or when the AAD ends mid-block.
                if (fill_inc == 4'd0 || rem_dec == 16'd0) begin
                  aes_go    = 1'b1;
                  aes_blk   = mac_upd;
                  state_nxt = S_AAD_W;
                end else begin
                  ovalid_nxt = 1'b1;
                end
              end
            end
            MODE_PAYLOAD: begin
              if (phase_r != PH_PAYLOAD) begin
                ostat_nxt  = ST_SEQ;
                ovalid_nxt = 1'b1;
              end else if (pos_r >= total_r) begin
                ostat_nxt  = ST_OVERRUN;
                ovalid_nxt = 1'b1;
              end else begin
                db_nxt = f_db;
                if (k == 4'd0) begin
                  cb_nxt    = put_tail(cb_r, {36'h0, pos_r[31:4]} + 64'd1, eff_l);
                  aes_go    = 1'b1;
                  aes_blk   = cb_nxt;
                  state_nxt = S_KS_W;
                end else begin
                  state_nxt = S_PAY;
                end
              end
            end
            default: begin
              if (phase_r == PH_PAYLOAD && pos_r == total_r) begin
                if (k != 4'd0) begin
                  aes_go    = 1'b1;
                  aes_blk   = mac_r;
                  state_nxt = S_FINMAC_W;
                end else begin
                  state_nxt = S_FINKS;
                end
              end else if (phase_r == PH_DONE) begin
                state_nxt = S_TAG;
              end else if (phase_r == PH_IDLE) begin
                ostat_nxt  = ST_SEQ;
                ovalid_nxt = 1'b1;
              end else begin
                ostat_nxt  = ST_EARLY;
                ovalid_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      S_START_W: begin
        if (aes_done) begin
          // Fold in the two-byte AAD length prefix.
          mac_nxt    = aes_out ^ ((rem_r != 16'd0) ? {rem_r, 112'h0} : 128'h0);
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_AAD_W: begin
        if (aes_done) begin
          mac_nxt    = aes_out;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_KS_W: begin
        if (aes_done) begin
          ks_nxt    = aes_out;
          state_nxt = S_PAY;
        end
      end
      S_PAY: begin
        mac_upd[8*(15-k) +: 8] = mac_r[8*(15-k) +: 8] ^ (dir_r ? db_r : ob);
        mac_nxt   = mac_upd;
        pos_nxt   = pos_inc;
        obyte_nxt = ob;
        if (pos_inc[3:0] == 4'd0) begin
          aes_go    = 1'b1;
          aes_blk   = mac_upd;
          state_nxt = S_PAYMAC_W;
        end else begin
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_PAYMAC_W: begin
        if (aes_done) begin
          mac_nxt    = aes_out;
          ovalid_nxt = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_FINMAC_W: begin
        if (aes_done) begin
          mac_nxt   = aes_out;
          state_nxt = S_FINKS;
        end
      end
      S_FINKS: begin
        // Counter zero gives the block that masks the tag.
        cb_nxt    = put_tail(cb_r, 64'h0, eff_l);
        aes_go    = 1'b1;
        aes_blk   = cb_nxt;
        state_nxt = S_FINKS_W;
      end
      S_FINKS_W: begin
        if (aes_done) begin
          ks_nxt    = aes_out;
          phase_nxt = PH_DONE;
          state_nxt = S_TAG;
        end
      end
      S_TAG: begin
        otagh_nxt  = tagx[127:64];
        otagl_nxt  = tagx[63:0];
        ovalid_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    db_r    <= db_nxt;
    obyte_r <= obyte_nxt;
    otagh_r <= otagh_nxt;
    otagl_r <= otagl_nxt;
    ostat_r <= ostat_nxt;
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_IDLE;
      ovalid_r <= 1'b0;
      mac_r    <= '0;
      cb_r     <= '0;
      ks_r     <= '0;
      pos_r    <= '0;
      total_r  <= '0;
      rem_r    <= '0;
      fill_r   <= '0;
      dir_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      ovalid_r <= ovalid_nxt;
      mac_r    <= mac_nxt;
      cb_r     <= cb_nxt;
      ks_r     <= ks_nxt;
      pos_r    <= pos_nxt;
      total_r  <= total_nxt;
      rem_r    <= rem_nxt;
      fill_r   <= fill_nxt;
      dir_r    <= dir_nxt;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {6'h00, ostat_r, otagl_r, otagh_r, obyte_r};

endmodule
`default_nettype wire
